// ===== hw/rtl/wsfr_pkg.sv =====
`default_nettype none

package wsfr_pkg;

  // Parser phases within one frame.
  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_PAY,
    PH_HALT
  } phase_t;

  // Frame opcodes recognised by the parser.
  localparam logic [3:0] OPC_CONT  = 4'h0;
  localparam logic [3:0] OPC_TEXT  = 4'h1;
  localparam logic [3:0] OPC_BIN   = 4'h2;
  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;
  localparam logic [3:0] OPC_PONG  = 4'hA;

  // Payload tags.
  localparam logic [1:0] KIND_BIN   = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_DROP  = 2'd3;

  // Sticky status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MASKED   = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_NESTED   = 3'd3;
  localparam logic [2:0] ST_STRAY    = 3'd4;
  localparam logic [2:0] ST_BAD_OPC  = 3'd5;
  localparam logic [2:0] ST_CLOSED   = 3'd6;

  // Short length codes that select an extended length.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Only the first bytes of a close payload are echoed.
  localparam logic [6:0] CLOSE_ECHO_MAX = 7'd125;

  localparam logic [31:0] MAX_MSG_RESET = 32'd16777216;

endpackage

`default_nettype wire

// ===== hw/rtl/websocket_frame_receiver_top.sv =====
`default_nettype none

// Byte-serial receiver for unmasked server WebSocket frames. One byte is taken per beat
// and each byte yields exactly one result beat, tagging payload bytes as binary message
// data, ping echo, close echo or discarded, with frame and message end flags and a
// sticky status. The parser takes one byte per clock: all header and length checks for
// a byte are combinational between the input handshake and the result register, and
// a new byte is accepted while the previous result is still held, as long as the
// result register is free or being emptied in the same cycle. After an error or a
// close frame the parser stays halted until reset. max_message_bytes may be written
// only while the block is idle.
module websocket_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             data_valid,
  output logic [7:0]       data_byte,
  output logic [1:0]       payload_kind,
  output logic             frame_done,
  output logic             message_done,
  output logic [2:0]       status
);

  // Parser state.
  wsfr_pkg::phase_t phase, phase_next;
  logic        frame_fin, frame_fin_next;
  logic [3:0]  frame_opcode, frame_opcode_next;
  logic [31:0] len_acc, len_acc_next;
  logic        len_ovf, len_ovf_next;
  logic [3:0]  ext_count, ext_count_next;
  logic [31:0] payload_remaining, payload_remaining_next;
  logic        in_frag, in_frag_next;
  logic [31:0] msg_total, msg_total_next;
  logic [6:0]  close_index, close_index_next;
  logic [2:0]  sticky_status, sticky_status_next;
  logic [31:0] max_message_bytes;

  // Result of the current beat.
  logic        r_dv;
  logic [7:0]  r_db;
  logic [1:0]  r_kind;
  logic        r_fd;
  logic        r_md;

  // Header completion inputs.
  logic        hc_go;
  logic [31:0] hc_len;
  logic        hc_ovf;
  logic [32:0] hc_sum;
  logic        in_acc;

  // A byte is taken when the result register is empty or drains this cycle.
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign hc_sum   = {1'b0, msg_total} + {1'b0, hc_len};

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_bytes <= wsfr_pkg::MAX_MSG_RESET;
    end else if (cfg_wr_en) begin
      max_message_bytes <= cfg_wr_data;
    end
  end

  // Next state and result for one byte.
  always_comb begin
    phase_next             = phase;
    frame_fin_next         = frame_fin;
    frame_opcode_next      = frame_opcode;
    len_acc_next           = len_acc;
    len_ovf_next           = len_ovf;
    ext_count_next         = ext_count;
    payload_remaining_next = payload_remaining;
    in_frag_next           = in_frag;
    msg_total_next         = msg_total;
    close_index_next       = close_index;
    sticky_status_next     = sticky_status;
    r_dv   = 1'b0;
    r_db   = 8'd0;
    r_kind = wsfr_pkg::KIND_DROP;
    r_fd   = 1'b0;
    r_md   = 1'b0;
    hc_go  = 1'b0;
    hc_len = 32'd0;
    hc_ovf = 1'b0;

    unique case (phase)
      wsfr_pkg::PH_HDR0: begin
        frame_fin_next    = rx_byte[7];
        frame_opcode_next = rx_byte[3:0];
        phase_next        = wsfr_pkg::PH_HDR1;
      end
      wsfr_pkg::PH_HDR1: begin
        if (rx_byte[7]) begin
          sticky_status_next = wsfr_pkg::ST_MASKED;
          phase_next         = wsfr_pkg::PH_HALT;
        end else begin
          len_acc_next = 32'd0;
          len_ovf_next = 1'b0;
          if (rx_byte[6:0] == wsfr_pkg::LEN_EXT16) begin
            ext_count_next = wsfr_pkg::EXT16_BYTES;
            phase_next     = wsfr_pkg::PH_EXT;
          end else if (rx_byte[6:0] == wsfr_pkg::LEN_EXT64) begin
            ext_count_next = wsfr_pkg::EXT64_BYTES;
            phase_next     = wsfr_pkg::PH_EXT;
          end else begin
            hc_go  = 1'b1;
            hc_len = {25'd0, rx_byte[6:0]};
          end
        end
      end
      wsfr_pkg::PH_EXT: begin
        // Big-endian shift; anything pushed out of the low 32 bits marks oversize.
        len_acc_next   = {len_acc[23:0], rx_byte};
        len_ovf_next   = len_ovf || (len_acc[31:24] != 8'd0);
        ext_count_next = ext_count - 4'd1;
        if (ext_count == 4'd1) begin
          hc_go  = 1'b1;
          hc_len = len_acc_next;
          hc_ovf = len_ovf_next;
        end
      end
      wsfr_pkg::PH_PAY: begin
        if (frame_opcode == wsfr_pkg::OPC_CONT || frame_opcode == wsfr_pkg::OPC_BIN) begin
          r_dv   = 1'b1;
          r_db   = rx_byte;
          r_kind = wsfr_pkg::KIND_BIN;
        end else if (frame_opcode == wsfr_pkg::OPC_PING) begin
          r_dv   = 1'b1;
          r_db   = rx_byte;
          r_kind = wsfr_pkg::KIND_PING;
        end else if (frame_opcode == wsfr_pkg::OPC_CLOSE
                     && close_index < wsfr_pkg::CLOSE_ECHO_MAX) begin
          r_dv             = 1'b1;
          r_db             = rx_byte;
          r_kind           = wsfr_pkg::KIND_CLOSE;
          close_index_next = close_index + 7'd1;
        end
        payload_remaining_next = payload_remaining - 32'd1;
        if (payload_remaining == 32'd1) begin
          r_fd = 1'b1;
          r_md = frame_fin && (frame_opcode == wsfr_pkg::OPC_CONT
                               || frame_opcode == wsfr_pkg::OPC_BIN);
          phase_next = (frame_opcode == wsfr_pkg::OPC_CLOSE) ? wsfr_pkg::PH_HALT
                                                             : wsfr_pkg::PH_HDR0;
        end
      end
      wsfr_pkg::PH_HALT: begin
        phase_next = wsfr_pkg::PH_HALT;
      end
      default: begin
        phase_next = wsfr_pkg::PH_HALT;
      end
    endcase

    // Checks on the complete header: size first, then the opcode rules.
    if (hc_go) begin
      if (hc_ovf || (hc_len > max_message_bytes)) begin
        sticky_status_next = wsfr_pkg::ST_TOO_BIG;
        phase_next         = wsfr_pkg::PH_HALT;
      end else begin
        priority if (frame_opcode == wsfr_pkg::OPC_BIN) begin
          if (in_frag) begin
            sticky_status_next = wsfr_pkg::ST_NESTED;
            phase_next         = wsfr_pkg::PH_HALT;
          end else begin
            in_frag_next   = !frame_fin;
            msg_total_next = hc_len;
          end
        end else if (frame_opcode == wsfr_pkg::OPC_CONT) begin
          if (!in_frag) begin
            sticky_status_next = wsfr_pkg::ST_STRAY;
            phase_next         = wsfr_pkg::PH_HALT;
          end else if (hc_sum > {1'b0, max_message_bytes}) begin
            sticky_status_next = wsfr_pkg::ST_TOO_BIG;
            phase_next         = wsfr_pkg::PH_HALT;
          end else begin
            msg_total_next = hc_sum[31:0];
            if (frame_fin) begin
              in_frag_next = 1'b0;
            end
          end
        end else if (frame_opcode == wsfr_pkg::OPC_CLOSE) begin
          sticky_status_next = wsfr_pkg::ST_CLOSED;
          close_index_next   = 7'd0;
        end else if (frame_opcode == wsfr_pkg::OPC_TEXT || frame_opcode == wsfr_pkg::OPC_PING
                     || frame_opcode == wsfr_pkg::OPC_PONG) begin
          sticky_status_next = sticky_status;
        end else begin
          sticky_status_next = wsfr_pkg::ST_BAD_OPC;
          phase_next         = wsfr_pkg::PH_HALT;
        end

        // A valid header either opens the payload or, at zero length, ends the frame.
        if (phase_next != wsfr_pkg::PH_HALT) begin
          payload_remaining_next = hc_len;
          if (hc_len == 32'd0) begin
            r_fd = 1'b1;
            r_md = frame_fin && (frame_opcode == wsfr_pkg::OPC_CONT
                                 || frame_opcode == wsfr_pkg::OPC_BIN);
            phase_next = (frame_opcode == wsfr_pkg::OPC_CLOSE) ? wsfr_pkg::PH_HALT
                                                               : wsfr_pkg::PH_HDR0;
          end else begin
            phase_next = wsfr_pkg::PH_PAY;
          end
        end
      end
    end
  end

  // Parser state registers, updated on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= wsfr_pkg::PH_HDR0;
      frame_fin         <= 1'b0;
      frame_opcode      <= 4'd0;
      len_acc           <= 32'd0;
      len_ovf           <= 1'b0;
      ext_count         <= 4'd0;
      payload_remaining <= 32'd0;
      in_frag           <= 1'b0;
      msg_total         <= 32'd0;
      close_index       <= 7'd0;
      sticky_status     <= wsfr_pkg::ST_OK;
    end else if (in_acc) begin
      phase             <= phase_next;
      frame_fin         <= frame_fin_next;
      frame_opcode      <= frame_opcode_next;
      len_acc           <= len_acc_next;
      len_ovf           <= len_ovf_next;
      ext_count         <= ext_count_next;
      payload_remaining <= payload_remaining_next;
      in_frag           <= in_frag_next;
      msg_total         <= msg_total_next;
      close_index       <= close_index_next;
      sticky_status     <= sticky_status_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_valid   <= r_dv;
      data_byte    <= r_db;
      payload_kind <= r_kind;
      frame_done   <= r_fd;
      message_done <= r_md;
      status       <= sticky_status_next;
    end
  end

endmodule

`default_nettype wire
